### hw/rtl/c_comment_strip_tab_compact_top_assert.svh
// Assertion macros for the comment stripper top level.
// Depends on signals named clock and reset in the module that uses them.
`ifndef C_COMMENT_STRIP_TAB_COMPACT_TOP_ASSERT_SVH
`define C_COMMENT_STRIP_TAB_COMPACT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define CCSTC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ccstc assertion failed");
`define CCSTC_NEVER(lbl, expr) \
   `CCSTC_ASSERT(lbl, !(expr))
`else
`define CCSTC_ASSERT(lbl, prop)
`define CCSTC_NEVER(lbl, expr)
`endif

`endif

### hw/rtl/ccstc_pkg.sv
// Package for the comment stripper: item types, controller command and status
// types, and character constants. No dependencies.
`default_nettype none

package ccstc_pkg;

   localparam int PEND_W = 7;
   localparam int CNT_W  = 6;

   localparam logic [CNT_W-1:0] RES_CAP = 6'd34;

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic              out_free;
      logic              more;
      logic [PEND_W-1:0] pend;
   } status_type;

endpackage

`default_nettype wire

### hw/rtl/ccstc_ctrl.sv
// Controller for the comment stripper: accepts items and sequences byte runs.
// Depends on ccstc_pkg.
`default_nettype none

module ccstc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire ccstc_pkg::status_type status,
   output ccstc_pkg::cmd_type        cmd
);
   import ccstc_pkg::*;

   typedef enum logic {ST_IDLE, ST_EMIT} state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            cmd.load  = req_valid & status.out_free;
            if (cmd.load && status.more) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.step = status.out_free;
            if (cmd.step && !status.more) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ccstc_dp.sv
// Datapath for the comment stripper: scan state, run generator and output register.
// Depends on ccstc_pkg.
`default_nettype none

module ccstc_dp #(
   parameter int TAB_SPACES  = 4,
   parameter int MAX_PENDING = 124
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ccstc_pkg::req_type    req_data,
   input  wire ccstc_pkg::cmd_type    cmd,
   output ccstc_pkg::status_type      status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ccstc_pkg::rsp_type         rsp_data
);
   import ccstc_pkg::*;

   typedef enum logic [3:0] {
      M_NORMAL, M_STR, M_STR_ESC, M_CHR, M_CHR_ESC,
      M_LINE_CMT, M_BLK_CMT, M_BLK_STAR, M_SLASH
   } mode_type;

   localparam logic [PEND_W-1:0] TAB_N = PEND_W'(TAB_SPACES);
   localparam logic [PEND_W-1:0] MAX_N = PEND_W'(MAX_PENDING);

   mode_type          mode_ff, mode_in;
   logic              ls_ff, ls_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              nl_ff, nl_in;

   logic              slash_ff, slash_in;
   logic [PEND_W-1:0] rem_ff, rem_in;
   logic              fv_ff, fv_in;
   logic [7:0]        fb_ff, fb_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              f_slash, f_fv, norm, ls_pre;
   logic [PEND_W-1:0] f_spaces;
   logic [7:0]        c;

   logic              src_slash, src_fv, has_byte, left, more_w, emit;
   logic [PEND_W-1:0] src_rem;
   logic [7:0]        src_fb, out_b;
   logic [CNT_W-1:0]  src_cnt;

   // Next scan state and the byte run caused by the offered item.
   always_comb begin
      c        = req_data.in_byte;
      mode_in  = mode_ff;
      ls_in    = ls_ff;
      pend_in  = pend_ff;
      nl_in    = nl_ff;
      f_slash  = 1'b0;
      f_spaces = '0;
      f_fv     = 1'b0;
      norm     = 1'b0;
      ls_pre   = 1'b0;
      if (req_data.end_of_input) begin
         f_slash  = (mode_ff == M_SLASH);
         f_spaces = pend_ff;
         mode_in  = M_NORMAL;
         ls_in    = 1'b1;
         pend_in  = '0;
         nl_in    = 1'b0;
      end else begin
         case (mode_ff)
            M_STR: begin
               f_fv = 1'b1; ls_in = 1'b0; nl_in = 1'b0;
               if (c == CH_BSLASH) begin
                  mode_in = M_STR_ESC;
               end else if (c == CH_DQUOTE) begin
                  mode_in = M_NORMAL;
               end
            end
            M_CHR: begin
               f_fv = 1'b1; ls_in = 1'b0; nl_in = 1'b0;
               if (c == CH_BSLASH) begin
                  mode_in = M_CHR_ESC;
               end else if (c == CH_SQUOTE) begin
                  mode_in = M_NORMAL;
               end
            end
            M_STR_ESC: begin
               f_fv = 1'b1; ls_in = 1'b0; nl_in = 1'b0; mode_in = M_STR;
            end
            M_CHR_ESC: begin
               f_fv = 1'b1; ls_in = 1'b0; nl_in = 1'b0; mode_in = M_CHR;
            end
            M_LINE_CMT: begin
               if (c == CH_NL) begin
                  mode_in = M_NORMAL;
               end
            end
            M_BLK_CMT: begin
               if (c == CH_STAR) begin
                  mode_in = M_BLK_STAR;
               end
            end
            M_BLK_STAR: begin
               if (c == CH_SLASH) begin
                  mode_in = M_NORMAL;
               end else if (c != CH_STAR) begin
                  mode_in = M_BLK_CMT;
               end
            end
            M_SLASH: begin
               if (c == CH_SLASH) begin
                  mode_in = M_LINE_CMT;
               end else if (c == CH_STAR) begin
                  mode_in = M_BLK_CMT;
               end else begin
                  f_slash = 1'b1; ls_in = 1'b0; nl_in = 1'b0;
                  mode_in = M_NORMAL; norm = 1'b1;
               end
            end
            default: begin
               mode_in = M_NORMAL;
               norm    = 1'b1;
            end
         endcase
         if (norm) begin
            ls_pre = ls_in;
            if (ls_pre && c == CH_SPACE) begin
               if (pend_in < MAX_N) begin
                  pend_in = pend_in + PEND_W'(1);
               end
            end else begin
               if ((ls_pre || c == CH_NL) && pend_in != '0) begin
                  f_spaces = pend_in;
                  pend_in  = '0;
                  ls_in    = 1'b0;
                  nl_in    = 1'b0;
               end
               if (ls_pre && c == CH_TAB) begin
                  f_fv = 1'b1; ls_in = 1'b0; nl_in = 1'b0;
               end else if (c == CH_SLASH) begin
                  mode_in = M_SLASH;
               end else if (c == CH_DQUOTE) begin
                  f_fv = 1'b1; ls_in = 1'b0; nl_in = 1'b0; mode_in = M_STR;
               end else if (c == CH_SQUOTE) begin
                  f_fv = 1'b1; ls_in = 1'b0; nl_in = 1'b0; mode_in = M_CHR;
               end else if (c == CH_NL) begin
                  if (!nl_in) begin
                     f_fv  = 1'b1;
                     nl_in = 1'b1;
                  end
                  ls_in = 1'b1;
               end else begin
                  f_fv = 1'b1; ls_in = 1'b0; nl_in = 1'b0;
               end
            end
         end
      end
   end

   // One byte of the run per command: held slash, tabs, spaces, final byte.
   always_comb begin
      src_slash = cmd.load ? f_slash  : slash_ff;
      src_rem   = cmd.load ? f_spaces : rem_ff;
      src_fv    = cmd.load ? f_fv     : fv_ff;
      src_fb    = cmd.load ? c        : fb_ff;
      src_cnt   = cmd.load ? '0       : cnt_ff;
      has_byte  = src_slash | (src_rem != '0) | src_fv;
      slash_in  = src_slash;
      rem_in    = src_rem;
      fv_in     = src_fv;
      fb_in     = src_fb;
      if (src_slash) begin
         out_b    = CH_SLASH;
         slash_in = 1'b0;
      end else if (src_rem >= TAB_N) begin
         out_b  = CH_TAB;
         rem_in = src_rem - TAB_N;
      end else if (src_rem != '0) begin
         out_b  = CH_SPACE;
         rem_in = src_rem - PEND_W'(1);
      end else begin
         out_b = src_fb;
         fv_in = 1'b0;
      end
      cnt_in = src_cnt + CNT_W'(1);
      left   = slash_in | (rem_in != '0) | fv_in;
      more_w = left && (cnt_in != RES_CAP);
      emit   = (cmd.load | cmd.step) && has_byte;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.out_byte    = out_b;
         rsp_data_in.last_of_run = !more_w;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_NORMAL;
         ls_ff        <= 1'b1;
         pend_ff      <= '0;
         nl_ff        <= 1'b0;
         slash_ff     <= 1'b0;
         rem_ff       <= '0;
         fv_ff        <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            mode_ff <= mode_in;
            ls_ff   <= ls_in;
            pend_ff <= pend_in;
            nl_ff   <= nl_in;
         end
         if (cmd.load || cmd.step) begin
            slash_ff <= slash_in;
            rem_ff   <= rem_in;
            fv_ff    <= fv_in;
            cnt_ff   <= cnt_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load || cmd.step) begin
         fb_ff <= fb_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.more     = emit && more_w;
   assign status.pend     = pend_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

`default_nettype wire

### hw/rtl/c_comment_strip_tab_compact_top.sv
// The first result byte of an item is valid in the cycle after the item is accepted.
// An item gives a run of bytes (held slash, tabs and spaces of an indent, final byte),
// one output register write per cycle while the output register is free; no new item
// is taken until the run ends. Results are capped at 34 per item.
// Reset is synchronous: normal mode at line start, no pending spaces, output empty.
`default_nettype none
`include "c_comment_strip_tab_compact_top_assert.svh"

module c_comment_strip_tab_compact_top #(
   parameter int TAB_SPACES  = 4,
   parameter int MAX_PENDING = 124
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire ccstc_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output ccstc_pkg::rsp_type      rsp_data
);
   import ccstc_pkg::*;

   cmd_type    cmd;
   status_type status;

   ccstc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ccstc_dp #(
      .TAB_SPACES  (TAB_SPACES),
      .MAX_PENDING (MAX_PENDING)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // An item is only taken when the output register can take its first byte.
   `CCSTC_ASSERT(a_accept_out_free, (req_valid && req_ready) |-> (!rsp_valid || rsp_ready))
   `CCSTC_NEVER(a_pend_bound, status.pend > PEND_W'(MAX_PENDING))
   `CCSTC_ASSERT(a_eoi_clears, (req_valid && req_ready && req_data.end_of_input) |=> (status.pend == '0))
   `CCSTC_NEVER(a_load_step_excl, cmd.load && cmd.step)

endmodule

`default_nettype wire
